// File: rtl/gbnsw_pkg.sv
// Shared types and constants for the Go-Back-N sender window block.
// Holds the command and register codes, the control word layout and the microcode ROM.
// No dependencies; imported by go_back_n_sender_window_top.
`default_nettype none

package gbnsw_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_PACKET_COUNT  = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  typedef logic [3:0] op_t;
  typedef logic [3:0] cond_t;
  typedef logic [3:0] upc_t;

  // Datapath operations.
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_FETCH      = 4'd1;
  localparam op_t OP_OFFER      = 4'd2;
  localparam op_t OP_ACK_DIFF   = 4'd3;
  localparam op_t OP_ACK_APPLY  = 4'd4;
  localparam op_t OP_ACK_STATUS = 4'd5;
  localparam op_t OP_TICK_INC   = 4'd6;
  localparam op_t OP_BURST_INIT = 4'd7;
  localparam op_t OP_RESEND     = 4'd8;

  // Jump conditions; a true condition loads the target, otherwise the step counter advances.
  localparam cond_t C_NEVER      = 4'd0;
  localparam cond_t C_ALWAYS     = 4'd1;
  localparam cond_t C_NO_INPUT   = 4'd2;
  localparam cond_t C_CMD_ACK    = 4'd3;
  localparam cond_t C_CMD_TICK   = 4'd4;
  localparam cond_t C_NO_OFFER   = 4'd5;
  localparam cond_t C_BAD_ACK    = 4'd6;
  localparam cond_t C_TIMER_OFF  = 4'd7;
  localparam cond_t C_NO_TIMEOUT = 4'd8;
  localparam cond_t C_BURST_DONE = 4'd9;

  // Program addresses.
  localparam upc_t PC_FETCH     = 4'd0;
  localparam upc_t PC_DISPATCH  = 4'd1;
  localparam upc_t PC_TICK_CHK  = 4'd2;
  localparam upc_t PC_OFFER_CHK = 4'd3;
  localparam upc_t PC_OFFER     = 4'd4;
  localparam upc_t PC_ACK       = 4'd5;
  localparam upc_t PC_ACK_DIFF  = 4'd6;
  localparam upc_t PC_ACK_APPLY = 4'd7;
  localparam upc_t PC_ACK_STAT  = 4'd8;
  localparam upc_t PC_TICK      = 4'd9;
  localparam upc_t PC_TICK_INC  = 4'd10;
  localparam upc_t PC_TIMEOUT   = 4'd11;
  localparam upc_t PC_BURST     = 4'd12;
  localparam upc_t PC_BURST_CHK = 4'd13;
  localparam upc_t PC_RESEND    = 4'd14;
  localparam upc_t PC_SPARE     = 4'd15;

  // One control word: operation, output-producing flag, jump condition and target.
  typedef struct packed {
    op_t   op;
    logic  emit;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  function automatic ucode_t uword(input op_t op, input logic emit, input cond_t cond,
                                   input upc_t target);
    ucode_t w;
    w.op     = op;
    w.emit   = emit;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The sequencer program.
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    unique case (pc)
      PC_FETCH:     w = uword(OP_FETCH,      1'b0, C_NO_INPUT,   PC_FETCH);
      PC_DISPATCH:  w = uword(OP_NOP,        1'b0, C_CMD_ACK,    PC_ACK);
      PC_TICK_CHK:  w = uword(OP_NOP,        1'b0, C_CMD_TICK,   PC_TICK);
      PC_OFFER_CHK: w = uword(OP_NOP,        1'b0, C_NO_OFFER,   PC_FETCH);
      PC_OFFER:     w = uword(OP_OFFER,      1'b1, C_ALWAYS,     PC_FETCH);
      PC_ACK:       w = uword(OP_NOP,        1'b0, C_BAD_ACK,    PC_FETCH);
      PC_ACK_DIFF:  w = uword(OP_ACK_DIFF,   1'b0, C_NEVER,      PC_FETCH);
      PC_ACK_APPLY: w = uword(OP_ACK_APPLY,  1'b0, C_NEVER,      PC_FETCH);
      PC_ACK_STAT:  w = uword(OP_ACK_STATUS, 1'b1, C_ALWAYS,     PC_FETCH);
      PC_TICK:      w = uword(OP_NOP,        1'b0, C_TIMER_OFF,  PC_FETCH);
      PC_TICK_INC:  w = uword(OP_TICK_INC,   1'b0, C_NEVER,      PC_FETCH);
      PC_TIMEOUT:   w = uword(OP_NOP,        1'b0, C_NO_TIMEOUT, PC_FETCH);
      PC_BURST:     w = uword(OP_BURST_INIT, 1'b0, C_NEVER,      PC_FETCH);
      PC_BURST_CHK: w = uword(OP_NOP,        1'b0, C_BURST_DONE, PC_FETCH);
      PC_RESEND:    w = uword(OP_RESEND,     1'b1, C_ALWAYS,     PC_BURST_CHK);
      PC_SPARE:     w = uword(OP_NOP,        1'b0, C_ALWAYS,     PC_FETCH);
      default:      w = uword(OP_NOP,        1'b0, C_ALWAYS,     PC_FETCH);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/go_back_n_sender_window_top.sv
// Go-Back-N sender window control: microcoded sequencer, datapath and output register.
// Depends on gbnsw_pkg for command codes, register indexes and the microcode ROM.
//
// Usage:
//   The input channel (in_*) carries one command per transaction: offer the next packet,
//   an ack that arrived, or a time tick. The output channel (out_*) carries the packets
//   to transmit and ack status words; out_tlast marks the final result of one command.
//   The cfg_* channel writes packet_count (index 0) and timeout_ticks (index 1); it is
//   always ready; the user must write it only while the block is idle (not enforced).
// Sequencing:
//   One command is handled at a time by a 16-step microcode program that walks one
//   control word per cycle while no result-producing step stalls. A timeout re-sends
//   at most WINDOW packets. A refused offer, bad ack or stopped timer returns to
//   fetch early.
// Reset:
//   rst_n low clears the window, counters and timer, stops the timer, sets packet_count
//   to 0 and timeout_ticks to 1000. No clearing pass is needed.
// Stalls:
//   Results sit in an output register; a step that produces a result waits there while
//   the receiver holds out_tready low, and nothing is lost or repeated.
`default_nettype none

module go_back_n_sender_window_top
  import gbnsw_pkg::*;
#(
  parameter int WINDOW    = 16,
  parameter int SEQ_SPACE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] ack_seq, [8] ack_good, [15:9] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // Result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] send_seq, [23:8] send_index,
                                       // [31:24] window_base, [32] all_acked, [39:33] zero
  output logic             out_tuser,  // [0] is_resend
  output logic             out_tlast,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int SW = $clog2(SEQ_SPACE);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [SW:0]   SEQ_SPAN1 = (SW + 1)'(SEQ_SPACE);
  localparam logic [SW+1:0] SEQ_SPAN2 = (SW + 2)'(SEQ_SPACE);
  localparam logic [16:0]   WIN_LIM   = 17'(WINDOW);
  localparam logic [CW-1:0] WIN_CAP   = CW'(WINDOW);
  localparam logic [19:0]   ELAPSED_MAX = 20'hFFFFF;
  localparam logic [19:0]   TIMEOUT_RST = 20'd1000;

  // Sum of two sequence numbers, wrapped into the sequence space.
  function automatic logic [SW-1:0] seq_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SEQ_SPAN1) begin
      s = s - SEQ_SPAN1;
    end
    return s[SW-1:0];
  endfunction

  // Ack sequence number reduced into the sequence space by compare and subtract.
  function automatic logic [SW-1:0] ack_mod(input logic [7:0] a);
    logic [8:0] r;
    r = {1'b0, a};
    for (int k = 2; k >= 0; k--) begin
      if ((SEQ_SPACE << k) <= 255 && r >= 9'(SEQ_SPACE << k)) begin
        r = r - 9'(SEQ_SPACE << k);
      end
    end
    return SW'(r);
  endfunction

  // Configuration and window state.
  logic [15:0]   pkt_count_r, pkt_count_nxt;
  logic [19:0]   timeout_r, timeout_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic [15:0]   sent_r, sent_nxt;
  logic [15:0]   acked_r, acked_nxt;
  logic          run_r, run_nxt;
  logic [19:0]   elapsed_r, elapsed_nxt;

  // Sequencer and per-command working registers.
  upc_t          pc_r, pc_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [SW-1:0] ackm_r, ackm_nxt;
  logic          good_r, good_nxt;
  logic [SW-1:0] diff_r, diff_nxt;
  logic          diff_ok_r, diff_ok_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cap_r, cap_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_seq_r, out_seq_nxt;
  logic [15:0]   out_idx_r, out_idx_nxt;
  logic          out_resend_r, out_resend_nxt;
  logic [7:0]    out_base_r, out_base_nxt;
  logic          out_all_r, out_all_nxt;
  logic          out_last_r, out_last_nxt;

  ucode_t        uw;
  logic          stall;
  logic          cond_true;
  logic [SW:0]   span;
  logic [SW-1:0] outst;
  logic [SW+1:0] dlin;
  logic [SW-1:0] dmod;
  logic          offer_ok;
  logic          all_acked;

  // Control word of the current step.
  assign uw = ucode_rom(pc_r);

  // A result-producing step waits while the output register is still full.
  assign stall = uw.emit && out_valid_r && !out_tready;

  assign in_tready = (uw.op == OP_FETCH);
  assign cfg_ready = 1'b1;

  // Outstanding packets: next minus base, wrapped into the sequence space.
  always_comb begin
    span = {1'b0, next_r} - {1'b0, base_r};
    if (span[SW]) begin
      outst = SW'(span + SEQ_SPAN1);
    end else begin
      outst = span[SW-1:0];
    end
  end

  // Distance from base to the packet after the acked one, wrapped into the sequence space.
  always_comb begin
    dlin = {2'b00, ackm_r} + (SW + 2)'(1) - {2'b00, base_r};
    if (dlin[SW+1]) begin
      dmod = SW'(dlin + SEQ_SPAN2);
    end else if (dlin >= SEQ_SPAN2) begin
      dmod = SW'(dlin - SEQ_SPAN2);
    end else begin
      dmod = dlin[SW-1:0];
    end
  end

  assign offer_ok  = (cmd_r == CMD_OFFER) && (17'(outst) < WIN_LIM) && (sent_r < pkt_count_r);
  assign all_acked = (acked_r == pkt_count_r);

  // Jump condition decode.
  always_comb begin
    unique case (uw.cond)
      C_NEVER:      cond_true = 1'b0;
      C_ALWAYS:     cond_true = 1'b1;
      C_NO_INPUT:   cond_true = !in_tvalid;
      C_CMD_ACK:    cond_true = (cmd_r == CMD_ACK);
      C_CMD_TICK:   cond_true = (cmd_r == CMD_TICK);
      C_NO_OFFER:   cond_true = !offer_ok;
      C_BAD_ACK:    cond_true = !good_r;
      C_TIMER_OFF:  cond_true = !run_r;
      C_NO_TIMEOUT: cond_true = (elapsed_r < timeout_r);
      C_BURST_DONE: cond_true = (cnt_r == cap_r);
      default:      cond_true = 1'b1;
    endcase
  end

  // Step counter and datapath operations.
  always_comb begin
    pkt_count_nxt  = pkt_count_r;
    timeout_nxt    = timeout_r;
    base_nxt       = base_r;
    next_nxt       = next_r;
    sent_nxt       = sent_r;
    acked_nxt      = acked_r;
    run_nxt        = run_r;
    elapsed_nxt    = elapsed_r;
    cmd_nxt        = cmd_r;
    ackm_nxt       = ackm_r;
    good_nxt       = good_r;
    diff_nxt       = diff_r;
    diff_ok_nxt    = diff_ok_r;
    cnt_nxt        = cnt_r;
    cap_nxt        = cap_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_seq_nxt    = out_seq_r;
    out_idx_nxt    = out_idx_r;
    out_resend_nxt = out_resend_r;
    out_base_nxt   = out_base_r;
    out_all_nxt    = out_all_r;
    out_last_nxt   = out_last_r;

    // Configuration writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PACKET_COUNT:  pkt_count_nxt = cfg_data[15:0];
        REG_TIMEOUT_TICKS: timeout_nxt   = cfg_data;
        default:           pkt_count_nxt = pkt_count_r;
      endcase
    end

    // Next step address.
    if (stall) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end

    if (!stall) begin
      unique case (uw.op)
        OP_NOP: begin
        end
        OP_FETCH: begin
          if (in_tvalid) begin
            cmd_nxt  = in_tuser;
            ackm_nxt = ack_mod(in_tdata[7:0]);
            good_nxt = in_tdata[8];
          end
        end
        OP_OFFER: begin
          if (outst == '0) begin
            run_nxt     = 1'b1;
            elapsed_nxt = '0;
          end
          next_nxt       = seq_add(next_r, SW'(1));
          sent_nxt       = sent_r + 16'd1;
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = 8'(next_r);
          out_idx_nxt    = sent_r;
          out_resend_nxt = 1'b0;
          out_base_nxt   = 8'(base_r);
          out_all_nxt    = all_acked;
          out_last_nxt   = 1'b1;
        end
        OP_ACK_DIFF: begin
          diff_nxt    = dmod;
          diff_ok_nxt = (dmod != '0) && (dmod <= outst);
        end
        OP_ACK_APPLY: begin
          if (diff_ok_r) begin
            base_nxt  = seq_add(base_r, diff_r);
            acked_nxt = acked_r + 16'(diff_r);
          end
          if (base_nxt == next_r) begin
            run_nxt = 1'b0;
          end else begin
            run_nxt     = 1'b1;
            elapsed_nxt = '0;
          end
        end
        OP_ACK_STATUS: begin
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = '0;
          out_idx_nxt    = '0;
          out_resend_nxt = 1'b0;
          out_base_nxt   = 8'(base_r);
          out_all_nxt    = all_acked;
          out_last_nxt   = 1'b1;
        end
        OP_TICK_INC: begin
          if (elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 20'd1;
          end
        end
        OP_BURST_INIT: begin
          elapsed_nxt = '0;
          cnt_nxt     = '0;
          if (17'(outst) > WIN_LIM) begin
            cap_nxt = WIN_CAP;
          end else begin
            cap_nxt = CW'(outst);
          end
        end
        OP_RESEND: begin
          cnt_nxt        = cnt_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = 8'(seq_add(base_r, SW'(cnt_r)));
          out_idx_nxt    = acked_r + 16'(cnt_r);
          out_resend_nxt = 1'b1;
          out_base_nxt   = 8'(base_r);
          out_all_nxt    = all_acked;
          out_last_nxt   = (cnt_nxt == cap_r);
        end
        default: begin
        end
      endcase
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_FETCH;
      pkt_count_r <= '0;
      timeout_r   <= TIMEOUT_RST;
      base_r      <= '0;
      next_r      <= '0;
      sent_r      <= '0;
      acked_r     <= '0;
      run_r       <= 1'b0;
      elapsed_r   <= '0;
      cnt_r       <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      pkt_count_r <= pkt_count_nxt;
      timeout_r   <= timeout_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      sent_r      <= sent_nxt;
      acked_r     <= acked_nxt;
      run_r       <= run_nxt;
      elapsed_r   <= elapsed_nxt;
      cnt_r       <= cnt_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ackm_r       <= ackm_nxt;
    good_r       <= good_nxt;
    diff_r       <= diff_nxt;
    diff_ok_r    <= diff_ok_nxt;
    out_seq_r    <= out_seq_nxt;
    out_idx_r    <= out_idx_nxt;
    out_resend_r <= out_resend_nxt;
    out_base_r   <= out_base_nxt;
    out_all_r    <= out_all_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Output channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_all_r, out_base_r, out_idx_r, out_seq_r};
  assign out_tuser  = out_resend_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The window never holds more than WINDOW outstanding packets.
  assert property (@(posedge clk) disable iff (!rst_n) 17'(outst) <= WIN_LIM)
    else $error("outstanding count exceeds the window");

  // The timer runs exactly when packets are outstanding.
  assert property (@(posedge clk) disable iff (!rst_n) run_r == (outst != '0))
    else $error("timer state disagrees with the outstanding count");

  // The burst index never passes the number of packets to re-send.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= cap_r)
    else $error("re-send index beyond burst length");

  // An accepted command transaction always moves the sequencer to dispatch.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (pc_r == PC_DISPATCH))
    else $error("sequencer did not dispatch an accepted command");
`endif

endmodule

`default_nettype wire
